/* hw/rtl/ile_pkg.sv */
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 7;
  localparam logic [VAL_W-1:0] NO_VALUE = '1;

  typedef enum logic [3:0] {
    OP_ADD_END   = 4'd0,
    OP_REM_END   = 4'd1,
    OP_ADD_FRONT = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_INSERT    = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_READ      = 4'd6,
    OP_WRITE     = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

/* hw/rtl/indexed_list_engine.sv */
// Bounded indexed list: entries in a single-port RAM, shifts done one entry at a time.
//
//   channel   handshake          payload
//   request   start / busy       op, item_value, position
//   result    done (strobe)      read_value, status, count_after
//
// A request is taken when start is high and busy is low; its result beat comes in the next
// cycle for errors, add end, write, clear, unused codes and add front on an empty list.
// Read, and removal with nothing above the entry, pass through S_CAPT; other removals loop
// S_SH_WR/S_SH_RD after it, insertion loops S_OG_WR/S_OG_RD, then S_OG_FIN. Each move after
// the first costs a read and a write on the RAM port. Synchronous reset empties the list;
// RAM is not cleared. The receiver cannot stall: done is high for one cycle per result.
module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        op,
  input  logic signed [ile_pkg::VAL_W-1:0]  item_value,
  input  logic [ile_pkg::POS_W-1:0]         position,
  output logic                              done,
  output logic signed [ile_pkg::VAL_W-1:0]  read_value,
  output logic [1:0]                        status,
  output logic [ile_pkg::CNT_OUT_W-1:0]     count_after
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;
  localparam int PW  = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CAPT   = 7'b0000010,
    S_SH_RD  = 7'b0000100,
    S_SH_WR  = 7'b0001000,
    S_OG_RD  = 7'b0010000,
    S_OG_WR  = 7'b0100000,
    S_OG_FIN = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] at, at_next;
  logic          is_remove, is_remove_next;
  logic [ile_pkg::VAL_W-1:0] val_hold;
  logic [ile_pkg::VAL_W-1:0] rv, rv_next;
  logic [1:0]    st, st_next;
  logic          done_next;
  logic          done_q;
  logic [ile_pkg::CNT_OUT_W-1:0] cnt_out, cnt_out_next;

  logic [ile_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [ile_pkg::VAL_W-1:0] rdata;
  logic                      mem_we;
  logic [AW-1:0]             mem_addr;
  logic [ile_pkg::VAL_W-1:0] mem_wdata;

  logic          accept;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic          in_range;
  logic          full;
  logic          empty;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  assign in_range  = pos_ext < count_ext;
  assign full      = (count == CAP_C);
  assign empty     = (count == '0);
  assign pos_c     = CW'(pos_ext);
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign cnt_inc   = count + CW'(1);
  assign cnt_dec   = count - CW'(1);

  assign done        = 1'b0 | done_q;
  assign read_value  = rv;
  assign status      = st;
  assign count_after = cnt_out;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    at_next        = at;
    is_remove_next = is_remove;
    rv_next        = rv;
    st_next        = st;
    done_next      = 1'b0;
    cnt_out_next   = cnt_out;
    mem_we         = 1'b0;
    mem_addr       = idx[AW-1:0];
    mem_wdata      = rdata;

    case (state)
      S_IDLE: begin
        if (accept) begin
          // default: a result with no value, given straight from idle
          rv_next   = ile_pkg::NO_VALUE;
          st_next   = ile_pkg::ST_OK;
          done_next = 1'b1;
          case (ile_pkg::op_t'(op))
            ile_pkg::OP_ADD_END: begin
              if (full) begin
                st_next = ile_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_addr   = count[AW-1:0];
                mem_wdata  = item_value;
                count_next = cnt_inc;
              end
            end
            ile_pkg::OP_REM_END, ile_pkg::OP_REM_FRONT, ile_pkg::OP_REM_AT,
            ile_pkg::OP_READ: begin
              if (empty && ile_pkg::op_t'(op) != ile_pkg::OP_READ) begin
                st_next = ile_pkg::ST_EMPTY;
              end else if (ile_pkg::op_t'(op) == ile_pkg::OP_REM_END) begin
                mem_addr       = cnt_dec[AW-1:0];
                idx_next       = cnt_dec;
                is_remove_next = 1'b1;
                done_next      = 1'b0;
                state_next     = S_CAPT;
              end else if (ile_pkg::op_t'(op) == ile_pkg::OP_REM_FRONT) begin
                mem_addr       = '0;
                idx_next       = '0;
                is_remove_next = 1'b1;
                done_next      = 1'b0;
                state_next     = S_CAPT;
              end else if (!in_range) begin
                st_next = ile_pkg::ST_RANGE;
              end else begin
                mem_addr       = pos_ext[AW-1:0];
                idx_next       = pos_c;
                is_remove_next = (ile_pkg::op_t'(op) == ile_pkg::OP_REM_AT);
                done_next      = 1'b0;
                state_next     = S_CAPT;
              end
            end
            ile_pkg::OP_ADD_FRONT, ile_pkg::OP_INSERT: begin
              if (ile_pkg::op_t'(op) == ile_pkg::OP_INSERT && !in_range) begin
                st_next = ile_pkg::ST_RANGE;
              end else if (full) begin
                st_next = ile_pkg::ST_FULL;
              end else begin
                at_next = (ile_pkg::op_t'(op) == ile_pkg::OP_INSERT) ? pos_c : '0;
                if (count == at_next) begin
                  // nothing to move: just place the value
                  mem_we     = 1'b1;
                  mem_addr   = at_next[AW-1:0];
                  mem_wdata  = item_value;
                  count_next = cnt_inc;
                end else begin
                  mem_addr   = cnt_dec[AW-1:0];
                  idx_next   = count;
                  done_next  = 1'b0;
                  state_next = S_OG_WR;
                end
              end
            end
            ile_pkg::OP_WRITE: begin
              if (!in_range) begin
                st_next = ile_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = pos_ext[AW-1:0];
                mem_wdata = item_value;
              end
            end
            ile_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
          if (done_next) begin
            cnt_out_next = ile_pkg::CNT_OUT_W'(count_next);
          end
        end
      end

      S_CAPT: begin
        rv_next = rdata;
        st_next = ile_pkg::ST_OK;
        if (is_remove && (({1'b0, idx} + CW1'(1)) < {1'b0, count})) begin
          mem_addr   = idx_inc[AW-1:0];
          state_next = S_SH_WR;
        end else begin
          if (is_remove) begin
            count_next = cnt_dec;
          end
          done_next    = 1'b1;
          cnt_out_next = ile_pkg::CNT_OUT_W'(count_next);
          state_next   = S_IDLE;
        end
      end

      S_SH_RD: begin
        mem_addr   = idx_inc[AW-1:0];
        state_next = S_SH_WR;
      end

      S_SH_WR: begin
        // move entry idx+1 down to idx
        mem_we    = 1'b1;
        mem_addr  = idx[AW-1:0];
        mem_wdata = rdata;
        idx_next  = idx_inc;
        if (({1'b0, idx} + CW1'(2)) < {1'b0, count}) begin
          state_next = S_SH_RD;
        end else begin
          count_next   = cnt_dec;
          done_next    = 1'b1;
          cnt_out_next = ile_pkg::CNT_OUT_W'(cnt_dec);
          state_next   = S_IDLE;
        end
      end

      S_OG_RD: begin
        mem_addr   = idx_dec[AW-1:0];
        state_next = S_OG_WR;
      end

      S_OG_WR: begin
        // move entry idx-1 up to idx
        mem_we    = 1'b1;
        mem_addr  = idx[AW-1:0];
        mem_wdata = rdata;
        idx_next  = idx_dec;
        state_next = (idx_dec > at) ? S_OG_RD : S_OG_FIN;
      end

      S_OG_FIN: begin
        mem_we       = 1'b1;
        mem_addr     = at[AW-1:0];
        mem_wdata    = val_hold;
        count_next   = cnt_inc;
        done_next    = 1'b1;
        cnt_out_next = ile_pkg::CNT_OUT_W'(cnt_inc);
        state_next   = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      done_q    <= 1'b0;
      is_remove <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      done_q    <= done_next;
      is_remove <= is_remove_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    at      <= at_next;
    rv      <= rv_next;
    st      <= st_next;
    cnt_out <= cnt_out_next;
    if (accept) begin
      val_hold <= item_value;
    end
  end

  // single-port RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata <= mem[mem_addr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("list count above capacity");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without a request in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ile_pkg::ST_FULL) |-> count_after == ile_pkg::CNT_OUT_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ile_pkg::ST_EMPTY) |-> count_after == '0)
    else $error("empty status with entries present");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the indexed list engine: directed, capacity and random list traffic.
`timescale 1ns / 1ps

module tb;

  localparam int CAPACITY = 64;
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [ile_pkg::VAL_W-1:0] value;
    ile_pkg::status_t                 st;
    logic [ile_pkg::CNT_OUT_W-1:0]    cnt;
  } outcome_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic [3:0]                           op;
  logic signed [ile_pkg::VAL_W-1:0]     item_value;
  logic [ile_pkg::POS_W-1:0]            position;
  logic                                 done;
  logic signed [ile_pkg::VAL_W-1:0]     read_value;
  logic [1:0]                           status;
  logic [ile_pkg::CNT_OUT_W-1:0]        count_after;

  // shadow copy of the list, updated as each request beat is taken
  logic signed [ile_pkg::VAL_W-1:0] list_mem [CAPACITY];
  int                               list_len;
  outcome_t                         pending_q[$];
  int                               errors;
  int                               result_idx;
  bit                               filling;

  indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .item_value(item_value), .position(position),
    .done(done), .read_value(read_value), .status(status), .count_after(count_after)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void open_slot(int at);
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
  endfunction

  function automatic logic signed [ile_pkg::VAL_W-1:0] take_slot(int at);
    logic signed [ile_pkg::VAL_W-1:0] v;
    v = list_mem[at];
    for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return v;
  endfunction

  function automatic outcome_t list_outcome(logic [3:0] code,
                                            logic signed [ile_pkg::VAL_W-1:0] val,
                                            logic [ile_pkg::POS_W-1:0] pos);
    outcome_t r;
    r.value = ile_pkg::NO_VALUE;
    r.st    = ile_pkg::ST_OK;
    case (code)
      ile_pkg::OP_ADD_END:
        if (list_len >= CAPACITY) r.st = ile_pkg::ST_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      ile_pkg::OP_REM_END:
        if (list_len == 0) r.st = ile_pkg::ST_EMPTY;
        else r.value = take_slot(list_len - 1);
      ile_pkg::OP_ADD_FRONT:
        if (list_len >= CAPACITY) r.st = ile_pkg::ST_FULL;
        else begin
          open_slot(0);
          list_mem[0] = val;
          list_len++;
        end
      ile_pkg::OP_REM_FRONT:
        if (list_len == 0) r.st = ile_pkg::ST_EMPTY;
        else r.value = take_slot(0);
      ile_pkg::OP_INSERT:
        // an index equal to the count is refused too
        if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
        else if (list_len >= CAPACITY) r.st = ile_pkg::ST_FULL;
        else begin
          open_slot(pos);
          list_mem[pos] = val;
          list_len++;
        end
      ile_pkg::OP_REM_AT:
        if (list_len == 0) r.st = ile_pkg::ST_EMPTY;
        else if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
        else r.value = take_slot(pos);
      ile_pkg::OP_READ:
        if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
        else r.value = list_mem[pos];
      ile_pkg::OP_WRITE:
        if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
        else list_mem[pos] = val;
      ile_pkg::OP_CLEAR:
        list_len = 0;
      default: ;
    endcase
    r.cnt = ile_pkg::CNT_OUT_W'(list_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns result %0d: %s", $time, result_idx, what);
    errors++;
  endtask

  // leaves start high on return; the caller lowers it when a gap follows
  task automatic send_request(input logic [3:0] code,
                              input logic signed [ile_pkg::VAL_W-1:0] val,
                              input logic [ile_pkg::POS_W-1:0] pos);
    op         <= code;
    item_value <= val;
    position   <= pos;
    start      <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_q.push_back(list_outcome(code, val, pos));
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done === 1'b1) begin
      if (pending_q.size() == 0) report_mismatch("result beat with nothing outstanding");
      else begin
        want = pending_q.pop_front();
        if (read_value !== want.value)
          report_mismatch($sformatf("read_value %0d, want %0d", read_value, want.value));
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (count_after !== want.cnt)
          report_mismatch($sformatf("count_after %0d, want %0d", count_after, want.cnt));
      end
      result_idx++;
    end
  end

  function automatic logic signed [ile_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return ile_pkg::NO_VALUE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ile_pkg::POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (list_len == 0 || r < 10) return ile_pkg::POS_W'($urandom_range(CAPACITY - 1));
    if (r < 20) return ile_pkg::POS_W'(list_len);
    if (r < 28) return ile_pkg::POS_W'(list_len - 1);
    return ile_pkg::POS_W'($urandom_range(list_len - 1));
  endfunction

  task automatic test_directed();
    send_request(ile_pkg::OP_REM_END, pick_value(), 0);
    send_request(ile_pkg::OP_REM_FRONT, pick_value(), 0);
    send_request(ile_pkg::OP_REM_AT, pick_value(), 0);
    send_request(ile_pkg::OP_READ, pick_value(), 0);
    send_request(ile_pkg::OP_WRITE, VAL_MAX, 0);
    send_request(ile_pkg::OP_INSERT, VAL_MIN, 0);
    send_request(ile_pkg::OP_ADD_END, VAL_MAX, 0);
    send_request(ile_pkg::OP_ADD_END, VAL_MIN, 63);
    send_request(ile_pkg::OP_ADD_FRONT, '0, 0);
    send_request(ile_pkg::OP_ADD_FRONT, ile_pkg::NO_VALUE, 0);
    send_request(ile_pkg::OP_INSERT, 32'sh1234_5678, 0);
    send_request(ile_pkg::OP_INSERT, 32'sh0bad_cafe, 5);
    send_request(ile_pkg::OP_INSERT, 32'sh5a5a_a5a5, 2);
    send_request(ile_pkg::OP_READ, '0, 0);
    send_request(ile_pkg::OP_READ, '0, 5);
    send_request(ile_pkg::OP_READ, '0, 63);
    send_request(ile_pkg::OP_WRITE, VAL_MIN, 63);
    send_request(ile_pkg::OP_WRITE, 32'sh7654_3210, 3);
    send_request(ile_pkg::OP_REM_AT, '0, 63);
    send_request(ile_pkg::OP_REM_AT, '0, 2);
    send_request(ile_pkg::OP_REM_FRONT, '0, 0);
    send_request(ile_pkg::OP_REM_END, '0, 0);
    send_request(OP_SPARE_LO, VAL_MAX, 63);
    send_request(OP_SPARE_HI, VAL_MIN, 0);
    send_request(ile_pkg::OP_CLEAR, VAL_MAX, 63);
    send_request(ile_pkg::OP_REM_END, '0, 0);
    send_request(ile_pkg::OP_ADD_END, 32'sh0000_0001, 0);
  endtask

  task automatic test_capacity();
    send_request(ile_pkg::OP_CLEAR, '0, 0);
    while (list_len < CAPACITY) send_request(ile_pkg::OP_ADD_END, pick_value(), 0);
    send_request(ile_pkg::OP_ADD_END, pick_value(), 0);
    send_request(ile_pkg::OP_ADD_FRONT, pick_value(), 0);
    send_request(ile_pkg::OP_INSERT, pick_value(), 10);
    send_request(ile_pkg::OP_INSERT, pick_value(), 63);
    send_request(ile_pkg::OP_READ, '0, 63);
    send_request(ile_pkg::OP_WRITE, VAL_MIN, 63);
    send_request(ile_pkg::OP_REM_AT, '0, 63);
    send_request(ile_pkg::OP_INSERT, pick_value(), 63);
    send_request(ile_pkg::OP_INSERT, VAL_MAX, 0);
    send_request(ile_pkg::OP_REM_AT, '0, 0);
    send_request(ile_pkg::OP_REM_FRONT, '0, 0);
    send_request(ile_pkg::OP_CLEAR, '0, 0);
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct);
    int r;
    logic [3:0] code;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, 6));
      // swing between filling and draining so the count sweeps the whole range
      if (list_len == 0) filling = 1'b1;
      else if (list_len >= CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      r = $urandom_range(99);
      if (r < 3) code = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (r < 4) code = ile_pkg::OP_CLEAR;
      else if (r < 64) begin
        case ($urandom_range(2))
          0: code = filling ? ile_pkg::OP_ADD_END : ile_pkg::OP_REM_END;
          1: code = filling ? ile_pkg::OP_ADD_FRONT : ile_pkg::OP_REM_FRONT;
          default: code = filling ? ile_pkg::OP_INSERT : ile_pkg::OP_REM_AT;
        endcase
      end
      else if (r < 84) code = ile_pkg::OP_READ;
      else code = ile_pkg::OP_WRITE;
      send_request(code, pick_value(), pick_position());
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    op         = ile_pkg::OP_ADD_END;
    item_value = '0;
    position   = '0;
    errors     = 0;
    result_idx = 0;
    list_len   = 0;
    filling    = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    wait_all_results();
    test_capacity();
    wait_all_results();
    run_random_phase(550, 24);
    run_random_phase(550, 79);
    run_random_phase(550, 0);
    wait_all_results();
    repeat (20) @(negedge clk);

    if (errors == 0) $display("indexed_list_engine: match");
    else $display("indexed_list_engine: mismatch");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("indexed_list_engine: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ile_pkg.sv
hw/rtl/indexed_list_engine.sv
dv/tb.sv
